FILE: sv/mfb_pkg.sv
// shared constants, command codes and control/status types for the
// monochrome framebuffer with paint and frame dump; no dependencies
package mfb_pkg;

   localparam int COLUMNS    = 128;
   localparam int PAGES      = 8;
   localparam int ROWS       = PAGES * 8;
   localparam int STORE_SIZE = COLUMNS * PAGES;

   localparam int X_W    = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int ADDR_W = $clog2(STORE_SIZE);
   localparam int SLOT_W = $clog2(COLUMNS + 3);

   // request kinds carried on req_tuser
   localparam logic [1:0] CMD_PAINT         = 2'd0;
   localparam logic [1:0] CMD_PAINT_REFRESH = 2'd1;
   localparam logic [1:0] CMD_TICK          = 2'd2;

   localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
   localparam logic [7:0] COL_LOW_CMD   = 8'h00;
   localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
   localparam logic [7:0] COL_MAX       = 8'(COLUMNS - 1);
   localparam logic [7:0] ROW_MAX       = 8'(ROWS - 1);

   // dump slots: three command bytes, then one per column
   localparam logic [SLOT_W-1:0] SLOT_PAGE_CMD  = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_COL_LOW   = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_COL_HIGH  = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_FIRST_COL = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_LAST      = SLOT_W'(COLUMNS + 2);

   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);

   typedef struct packed {
      logic accept;      // request transaction this cycle
      logic clear_en;    // write one zero byte of the clearing pass
      logic paint_load;  // latch a rectangle
      logic paint_step;  // read one byte of the rectangle walk
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic paint_last;
      logic rect_empty;
      logic is_paint;
      logic stage_busy;
      logic out_free;
   } dp_status_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                    input logic [X_W-1:0] col);
      store_addr = ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

FILE: sv/mfb_ctrl.sv
// controller state machine: clearing pass, idle, rectangle walk, write drain
// depends on mfb_pkg
module mfb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mfb_pkg::dp_status_type status,
   output mfb_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PAINT = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.accept     = 1'b0;
      cmd.clear_en   = 1'b0;
      cmd.paint_load = 1'b0;
      cmd.paint_step = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // a waiting tick byte may leave this cycle, so accept behind it
            req_tready = !status.stage_busy || status.out_free;
            cmd.accept = req_tvalid && req_tready;
            if (cmd.accept && status.is_paint && !status.rect_empty) begin
               cmd.paint_load = 1'b1;
               state_in       = ST_PAINT;
            end
         end
         ST_PAINT: begin
            cmd.paint_step = 1'b1;
            if (status.paint_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/mfb_datapath.sv
// datapath: frame store, rectangle walk with read-modify-write, dump
// counters, tick read stage and output register; depends on mfb_pkg
module mfb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mfb_pkg::ctrl_cmd_type  cmd,
   output mfb_pkg::dp_status_type status,
   input  logic [39:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [7:0] x_low, y_low, x_high, y_high;
   logic       pixel_on;
   logic [7:0] xh_clip, yh_clip;

   assign x_low    = req_tdata[7:0];
   assign y_low    = req_tdata[15:8];
   assign x_high   = req_tdata[23:16];
   assign y_high   = req_tdata[31:24];
   assign pixel_on = req_tdata[32];

   assign xh_clip = (x_high > mfb_pkg::COL_MAX) ? mfb_pkg::COL_MAX : x_high;
   assign yh_clip = (y_high > mfb_pkg::ROW_MAX) ? mfb_pkg::ROW_MAX : y_high;

   // ---------------- rectangle walk: columns inner, row groups outer
   logic [mfb_pkg::X_W-1:0]    px_ff, px_in, px_first_ff, px_last_ff;
   logic [mfb_pkg::PAGE_W-1:0] grp_ff, grp_in, grp_lo_ff, grp_hi_ff;
   logic [2:0]                 ylo_ff, yhi_ff;
   logic                       on_ff;
   logic [2:0]                 mask_lo, mask_hi;
   logic [7:0]                 step_mask;
   logic [mfb_pkg::ADDR_W-1:0] paint_addr;

   always_comb begin
      px_in  = px_ff;
      grp_in = grp_ff;
      if (cmd.paint_step) begin
         if (px_ff == px_last_ff) begin
            px_in  = px_first_ff;
            grp_in = grp_ff + 1'b1;
         end else begin
            px_in = px_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.paint_load) begin
         px_ff       <= mfb_pkg::X_W'(x_low);
         px_first_ff <= mfb_pkg::X_W'(x_low);
         px_last_ff  <= mfb_pkg::X_W'(xh_clip);
         grp_ff      <= mfb_pkg::PAGE_W'(y_low[7:3]);
         grp_lo_ff   <= mfb_pkg::PAGE_W'(y_low[7:3]);
         grp_hi_ff   <= mfb_pkg::PAGE_W'(yh_clip[7:3]);
         ylo_ff      <= y_low[2:0];
         yhi_ff      <= yh_clip[2:0];
         on_ff       <= pixel_on;
      end else begin
         px_ff  <= px_in;
         grp_ff <= grp_in;
      end
   end

   // row r of a group lives at bit 7-r
   assign mask_lo   = (grp_ff == grp_lo_ff) ? ylo_ff : 3'd0;
   assign mask_hi   = (grp_ff == grp_hi_ff) ? yhi_ff : 3'd7;
   assign step_mask = (8'hFF >> mask_lo) & (8'hFF << (3'd7 - mask_hi));
   assign paint_addr = mfb_pkg::store_addr(mfb_pkg::PAGE_LAST - grp_ff, px_ff);

   // ---------------- dump counters
   logic                       active_ff, active_in;
   logic [mfb_pkg::PAGE_W-1:0] rf_page_ff, rf_page_in;
   logic [mfb_pkg::SLOT_W-1:0] rf_slot_ff, rf_slot_in;
   logic                       tick_fire, restart;
   logic                       slot_end, page_end;
   logic [mfb_pkg::ADDR_W-1:0] tick_addr;

   assign tick_fire = cmd.accept && (req_tuser == mfb_pkg::CMD_TICK) && active_ff;
   assign restart   = cmd.accept && (req_tuser == mfb_pkg::CMD_PAINT_REFRESH);
   assign slot_end  = (rf_slot_ff == mfb_pkg::SLOT_LAST);
   assign page_end  = (rf_page_ff == mfb_pkg::PAGE_LAST);
   assign tick_addr = mfb_pkg::store_addr(rf_page_ff,
      mfb_pkg::X_W'(rf_slot_ff - mfb_pkg::SLOT_FIRST_COL));

   always_comb begin
      active_in  = active_ff;
      rf_page_in = rf_page_ff;
      rf_slot_in = rf_slot_ff;
      if (restart) begin
         active_in  = 1'b1;
         rf_page_in = '0;
         rf_slot_in = '0;
      end else if (tick_fire) begin
         if (slot_end) begin
            rf_slot_in = '0;
            if (page_end) begin
               rf_page_in = '0;
               active_in  = 1'b0;
            end else begin
               rf_page_in = rf_page_ff + 1'b1;
            end
         end else begin
            rf_slot_in = rf_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         rf_page_ff <= '0;
         rf_slot_ff <= '0;
      end else begin
         active_ff  <= active_in;
         rf_page_ff <= rf_page_in;
         rf_slot_ff <= rf_slot_in;
      end
   end

   // ---------------- frame store, one write and one registered read port
   logic [7:0]                 store_mem [mfb_pkg::STORE_SIZE];
   logic [7:0]                 rd_data_ff;
   logic                       rd_en, wr_en;
   logic [mfb_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic [7:0]                 wr_data;
   logic [mfb_pkg::ADDR_W-1:0] clr_addr_ff;
   logic                       wr_pend_ff;
   logic [mfb_pkg::ADDR_W-1:0] wr_addr_ff;
   logic [7:0]                 wr_mask_ff;

   assign rd_en   = cmd.paint_step || tick_fire;
   assign rd_addr = cmd.paint_step ? paint_addr : tick_addr;
   assign wr_en   = cmd.clear_en || wr_pend_ff;
   assign wr_addr = cmd.clear_en ? clr_addr_ff : wr_addr_ff;
   assign wr_data = cmd.clear_en ? 8'h00 :
                    on_ff ? (rd_data_ff | wr_mask_ff) : (rd_data_ff & ~wr_mask_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         wr_pend_ff  <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         wr_pend_ff <= cmd.paint_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.paint_step) begin
         wr_addr_ff <= paint_addr;
         wr_mask_ff <= step_mask;
      end
   end

   // ---------------- tick read stage and output register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_dnc_ff, s1_last_ff;
   logic       s1_move, out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_dnc_ff, rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && out_free;

   always_comb begin
      priority if (rf_slot_ff == mfb_pkg::SLOT_PAGE_CMD) begin
         s1_byte_in = mfb_pkg::PAGE_CMD_BASE + 8'(rf_page_ff);
      end else if (rf_slot_ff == mfb_pkg::SLOT_COL_LOW) begin
         s1_byte_in = mfb_pkg::COL_LOW_CMD;
      end else begin
         s1_byte_in = mfb_pkg::COL_HIGH_CMD;
      end
      s1_valid_in = tick_fire || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         s1_byte_ff <= s1_byte_in;
         s1_dnc_ff  <= (rf_slot_ff >= mfb_pkg::SLOT_FIRST_COL);
         s1_last_ff <= slot_end && page_end;
      end
      if (s1_move) begin
         rsp_byte_ff <= s1_dnc_ff ? rd_data_ff : s1_byte_ff;
         rsp_dnc_ff  <= s1_dnc_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_dnc_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.clear_last = (clr_addr_ff == mfb_pkg::ADDR_LAST);
   assign status.paint_last = (px_ff == px_last_ff) && (grp_ff == grp_hi_ff);
   assign status.rect_empty = (x_low > xh_clip) || (y_low > yh_clip);
   assign status.is_paint   = (req_tuser == mfb_pkg::CMD_PAINT) ||
                              (req_tuser == mfb_pkg::CMD_PAINT_REFRESH);
   assign status.stage_busy = s1_valid_ff;
   assign status.out_free   = out_free;

   // tick reads never land on top of a read-modify-write
   a_tick_no_rmw: assert property (@(posedge clock) disable iff (reset)
      tick_fire |-> !wr_pend_ff && !cmd.paint_step)
      else $error("tick read overlaps paint write");

   a_clear_no_paint: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> !wr_pend_ff && !cmd.paint_step && !cmd.accept)
      else $error("clearing pass overlaps other store traffic");

   a_stage_origin: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !$past(reset) |-> $past(tick_fire) || $past(s1_valid_ff))
      else $error("read stage valid without a tick");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_dnc_ff)
      else $error("frame end on a command byte");

   a_no_read_under_held_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |-> !rd_en)
      else $error("store read while tick byte still waits for the output");

endmodule

FILE: sv/mono_framebuffer_paint_refresh.sv
// top level of the monochrome page-mode framebuffer with paint and frame dump
// depends on mfb_pkg, mfb_ctrl and mfb_datapath
//
// channel  direction  tdata fields (low bit up)                         tuser / tlast
// req      in         x_low[7:0] y_low[15:8] x_high[23:16] y_high[31:24]  tuser: command
//                     pixel_on[32], zero fill to 40 bits
// rsp      out        spi_byte[7:0]                                      tuser: data_not_command
//                                                                         tlast: frame_end
//
// ticks: one per cycle while rsp keeps up and no paint runs; each byte passes the
//   read stage and output register; rate set by the single registered store read port
// paints: accepted, then each column byte touched (clipped columns times row groups)
//   is read and rewritten, then a write-drain state follows
// reset: synchronous; a clearing pass writes one store byte a cycle over the whole
//   store, with req_tready low until it ends
// stalls: a held rsp byte still lets one more tick be read behind it
module mono_framebuffer_paint_refresh (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // x_low, y_low, x_high, y_high, pixel_on
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // spi_byte
   output logic        rsp_tuser,   // data_not_command
   output logic        rsp_tlast    // frame_end
);

   mfb_pkg::ctrl_cmd_type  cmd;
   mfb_pkg::dp_status_type status;

   mfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mfb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/mfb_dump_checker.sv
// checker for the monochrome framebuffer: tracks the frame store and the dump
// state from accepted req transactions and compares rsp transactions with it
// depends on mfb_pkg
`timescale 1ns / 1ps

module mfb_dump_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // x_low, y_low, x_high, y_high, pixel_on
   input  logic [1:0]  req_tuser,   // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // spi_byte
   input  logic        rsp_tuser,   // data_not_command
   input  logic        rsp_tlast,   // frame_end
   output int          error_count,
   output int          pending_count
);

   typedef struct {
      logic [7:0] spi_byte;
      logic       data_not_command;
      logic       frame_end;
   } dump_byte_type;

   dump_byte_type dump_bytes_due[$];
   logic [7:0] shadow_frame [mfb_pkg::STORE_SIZE];
   bit         dump_active;
   int         dump_page;
   int         dump_slot;

   task automatic paint_shadow_rect(input int xl, input int yl, input int xh, input int yh,
                                    input bit on);
      int         idx;
      logic [7:0] mask;
      if (xl > xh || yl > yh) return;
      if (xh > mfb_pkg::COLUMNS - 1) xh = mfb_pkg::COLUMNS - 1;
      if (yh > mfb_pkg::ROWS - 1) yh = mfb_pkg::ROWS - 1;
      for (int x = xl; x <= xh; x++) begin
         for (int y = yl; y <= yh; y++) begin
            // row y sits in page PAGES-1-y/8, msb first within the byte
            idx  = (mfb_pkg::PAGES - 1 - y / 8) * mfb_pkg::COLUMNS + x;
            mask = 8'h80 >> (y % 8);
            shadow_frame[idx] = on ? (shadow_frame[idx] | mask) : (shadow_frame[idx] & ~mask);
         end
      end
   endtask

   task automatic next_dump_byte(output dump_byte_type b);
      b.frame_end = 1'b0;
      if (dump_slot == int'(mfb_pkg::SLOT_PAGE_CMD)) begin
         b.spi_byte         = mfb_pkg::PAGE_CMD_BASE + 8'(dump_page);
         b.data_not_command = 1'b0;
      end else if (dump_slot == int'(mfb_pkg::SLOT_COL_LOW)) begin
         b.spi_byte         = mfb_pkg::COL_LOW_CMD;
         b.data_not_command = 1'b0;
      end else if (dump_slot == int'(mfb_pkg::SLOT_COL_HIGH)) begin
         b.spi_byte         = mfb_pkg::COL_HIGH_CMD;
         b.data_not_command = 1'b0;
      end else begin
         b.spi_byte         = shadow_frame[dump_page * mfb_pkg::COLUMNS + dump_slot -
                                           int'(mfb_pkg::SLOT_FIRST_COL)];
         b.data_not_command = 1'b1;
      end
      dump_slot++;
      if (dump_slot > int'(mfb_pkg::SLOT_LAST)) begin
         dump_slot = 0;
         if (dump_page == mfb_pkg::PAGES - 1) begin
            dump_page   = 0;
            dump_active = 0;
            b.frame_end = 1'b1;
         end else begin
            dump_page++;
         end
      end
   endtask

   always @(posedge clock) begin
      dump_byte_type want;
      if (reset) begin
         foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
         dump_active = 0;
         dump_page   = 0;
         dump_slot   = 0;
         dump_bytes_due.delete();
      end else begin
         // results trail their tick by cycles, so retire before predicting
         if (rsp_tvalid && rsp_tready) begin
            if (dump_bytes_due.size() == 0) begin
               $error("unexpected rsp transaction: spi_byte %02h", rsp_tdata);
               error_count++;
            end else begin
               want = dump_bytes_due.pop_front();
               if (rsp_tdata !== want.spi_byte) begin
                  $error("spi_byte: expected %02h, actual %02h", want.spi_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.data_not_command) begin
                  $error("data_not_command: expected %0d, actual %0d",
                         want.data_not_command, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d", want.frame_end, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               mfb_pkg::CMD_PAINT, mfb_pkg::CMD_PAINT_REFRESH: begin
                  paint_shadow_rect(int'(req_tdata[7:0]), int'(req_tdata[15:8]),
                                    int'(req_tdata[23:16]), int'(req_tdata[31:24]),
                                    req_tdata[32]);
                  if (req_tuser == mfb_pkg::CMD_PAINT_REFRESH) begin
                     dump_active = 1;
                     dump_page   = 0;
                     dump_slot   = 0;
                  end
               end
               mfb_pkg::CMD_TICK: begin
                  if (dump_active) begin
                     next_dump_byte(want);
                     dump_bytes_due.push_back(want);
                  end
               end
               default: ;  // reserved code leaves everything alone
            endcase
         end
      end
      pending_count = dump_bytes_due.size();
   end

endmodule

FILE: tb/tb_mono_framebuffer_paint_refresh.sv
// top of the framebuffer testbench: clock, reset, paint and tick stimulus,
// response stalls, watchdog and verdict; depends on mfb_pkg, mfb_dump_checker and the block
`timescale 1ns / 1ps

module tb_mono_framebuffer_paint_refresh;

   localparam logic [1:0] CMD_RESERVED  = 2'd3;
   localparam int ITEM_TARGET    = 1750;
   localparam int FULL_DUMP      = (mfb_pkg::COLUMNS + 3) * mfb_pkg::PAGES;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // x_low, y_low, x_high, y_high, pixel_on
   logic [1:0]  req_tuser = mfb_pkg::CMD_PAINT;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // spi_byte
   logic        rsp_tuser;   // data_not_command
   logic        rsp_tlast;   // frame_end

   int fail_count;
   int pending_bytes;
   int items_sent = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mono_framebuffer_paint_refresh uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   mfb_dump_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .error_count   (fail_count),
      .pending_count (pending_bytes)
   );

   // receiver: segments of always-ready, coin-flip and long periodic stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_phase % 7) < 2;
      endcase
      stall_phase <= stall_phase + 1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // one req transaction; the sender sometimes idles between bursts of random length
   task automatic drive_req(input logic [1:0] cmd, input logic [7:0] xl, input logic [7:0] yl,
                            input logic [7:0] xh, input logic [7:0] yh, input logic on);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
         end else begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
         end
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, on, yh, xh, yl, xl};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      drive_req(mfb_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
   endtask

   // mostly small rectangles near the screen, a few large or malformed ones
   task automatic send_paint(input logic [1:0] cmd);
      logic [7:0] xl, yl, xh, yh;
      int shape;
      shape = $urandom_range(0, 7);
      if (shape == 0) begin
         xl = 8'($urandom_range(0, 255));
         yl = 8'($urandom_range(0, 255));
         xh = 8'($urandom_range(0, 255));
         yh = 8'($urandom_range(0, 255));
      end else if (shape == 1) begin
         xl = 8'($urandom_range(0, 127));
         yl = 8'($urandom_range(0, 63));
         xh = 8'($urandom_range(xl, 255));
         yh = 8'($urandom_range(yl, 255));
      end else begin
         xl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, 135));
         yl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, 70));
         xh = (xl > 8'd243) ? 8'd255 : xl + 8'($urandom_range(0, 12));
         yh = (yl > 8'd243) ? 8'd255 : yl + 8'($urandom_range(0, 12));
      end
      drive_req(cmd, xl, yl, xh, yh, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_dump_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_bytes != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int ticks_left;
      int pick;
      bit first_dump;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_tick();                                               // tick while idle
      drive_req(CMD_RESERVED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1); // ignored code
      drive_req(mfb_pkg::CMD_PAINT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      drive_req(mfb_pkg::CMD_PAINT, mfb_pkg::COL_MAX, mfb_pkg::ROW_MAX, mfb_pkg::COL_MAX,
                mfb_pkg::ROW_MAX, 1'b1);
      drive_req(mfb_pkg::CMD_PAINT, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      drive_req(mfb_pkg::CMD_PAINT, 8'd128, 8'd64, 8'd255, 8'd255, 1'b1);
      drive_req(mfb_pkg::CMD_PAINT, 8'd10, 8'd0, 8'd9, 8'd63, 1'b1);      // empty in x
      drive_req(mfb_pkg::CMD_PAINT, 8'd0, 8'd40, 8'd127, 8'd39, 1'b1);    // empty in y
      drive_req(mfb_pkg::CMD_PAINT, 8'd120, 8'd60, 8'd200, 8'd100, 1'b1); // partly off screen
      drive_req(mfb_pkg::CMD_PAINT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1);    // whole screen
      drive_req(mfb_pkg::CMD_PAINT, 8'd0, 8'd0, 8'd127, 8'd7, 1'b0);
      drive_req(mfb_pkg::CMD_PAINT, 8'd5, 8'd8, 8'd5, 8'd15, 1'b0);
      drive_req(mfb_pkg::CMD_PAINT, 8'd3, 8'd20, 8'd3, 8'd20, 1'b0);
      drive_req(mfb_pkg::CMD_PAINT_REFRESH, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
      repeat (4) send_tick();
      // paint columns of page 0, all but column 0 not yet sent by the dump
      drive_req(mfb_pkg::CMD_PAINT, 8'd0, 8'd56, 8'd10, 8'd63, 1'b0);
      repeat (3) send_tick();
      drive_req(mfb_pkg::CMD_PAINT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1); // restart mid dump
      repeat (2) send_tick();
      wait_dump_drained();

      // random part: restarted dumps fed with ticks, paints and noise in between
      first_dump = 1;
      while (items_sent < ITEM_TARGET) begin
         send_paint(mfb_pkg::CMD_PAINT_REFRESH);
         if (first_dump || ($urandom_range(0, 3) == 0 && items_sent < ITEM_TARGET - FULL_DUMP))
            ticks_left = FULL_DUMP + $urandom_range(0, 4);
         else
            ticks_left = $urandom_range(4, 300);
         // keep the last round close to the item target
         if (!first_dump && ticks_left > ITEM_TARGET - items_sent)
            ticks_left = ITEM_TARGET - items_sent;
         first_dump = 0;
         while (ticks_left > 0) begin
            pick = $urandom_range(0, 63);
            if (pick < 3) begin
               send_paint(mfb_pkg::CMD_PAINT);
            end else if (pick == 3) begin
               drive_req(CMD_RESERVED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end else begin
               send_tick();
               ticks_left--;
            end
         end
         if ($urandom_range(0, 2) == 0) wait_dump_drained();
      end

      wait_dump_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_bytes == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/mfb_pkg.sv
sv/mfb_ctrl.sv
sv/mfb_datapath.sv
sv/mono_framebuffer_paint_refresh.sv
tb/mfb_dump_checker.sv
tb/tb_mono_framebuffer_paint_refresh.sv
